// ----- src/b64d_pkg.sv -----
package b64d_pkg;

  localparam int LengthBits = 16;
  localparam int LenW       = 16;
  localparam logic [LenW-1:0] LenCap =
    (LengthBits >= LenW) ? {LenW{1'b1}} : LenW'((64'd1 << LengthBits) - 64'd1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam int ResDepth = 8;
  localparam int ResPtrW  = $clog2(ResDepth);
  localparam int ResCntW  = $clog2(ResDepth + 1);
  localparam int MaxRes   = 3;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharUnder = 8'h5F;
  localparam logic [7:0] CharComma = 8'h2C;

  typedef enum logic [1:0] {
    VAR_STD  = 2'd0,
    VAR_URL  = 2'd1,
    VAR_IMAP = 2'd2,
    VAR_ALT  = 2'd3
  } variant_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VARIANT = 2'd0,
    REG_PADDING = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_END  = 1'b1
  } in_kind_e;

  typedef enum logic {
    RES_DATA   = 1'b0,
    RES_STATUS = 1'b1
  } res_kind_e;

  typedef struct packed {
    logic            result_kind;
    logic [7:0]      data_byte;
    logic            status;
    logic [LenW-1:0] decoded_length;
    logic            last_in_run;
  } res_t;

  typedef struct packed {
    logic [1:0]        cnt;
    res_t [MaxRes-1:0] res;
  } push_t;

  // bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] sextet(input logic [7:0] c, input logic [1:0] alph_sel);
    logic [7:0] c62;
    logic [7:0] c63;
    logic [6:0] s;
    c62 = CharPlus;
    c63 = CharSlash;
    case (variant_e'(alph_sel))
      VAR_URL: begin
        c62 = CharDash;
        c63 = CharUnder;
      end
      VAR_IMAP: c63 = CharComma;
      default: ;
    endcase
    if (c inside {[8'h41:8'h5A]}) begin
      s = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      s = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      s = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == c62) begin
      s = 7'd62;
    end else if (c == c63) begin
      s = 7'd63;
    end else begin
      s = 7'h40;
    end
    return s;
  endfunction

endpackage

// ----- src/b64d_intf.sv -----
interface b64d_char_if;
  import b64d_pkg::*;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface b64d_res_if;
  import b64d_pkg::*;
  logic            valid;
  logic            ready;
  logic            result_kind;
  logic [7:0]      data_byte;
  logic            status;
  logic [LenW-1:0] decoded_length;
  logic            last_in_run;
  modport source (output valid, output result_kind, output data_byte, output status,
                  output decoded_length, output last_in_run, input ready);
  modport sink (input valid, input result_kind, input data_byte, input status,
                input decoded_length, input last_in_run, output ready);
endinterface

interface b64d_cfg_if;
  import b64d_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/b64d_core.sv -----
module b64d_core import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_vld_i,
  input  logic       in_kind_i,
  input  logic [7:0] in_char_i,
  output logic       in_rdy_o,
  input  logic       room_i,
  input  logic [1:0] alph_sel_i,
  input  logic       pad_on_i,
  output push_t      push_o
);

  logic            stg_vld_q;
  logic            stg_kind_q;
  logic [7:0]      stg_char_q;
  logic [7:0]      held_q [3];
  logic [1:0]      fill_q, fill_d;
  logic            pend_q, pend_d;
  logic            tail3_q, tail3_d;
  logic            err_q, err_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  logic            fire;
  logic            held_we;
  logic [6:0]      sx0, sx1, sx2, sx3;
  logic [7:0]      bsel [MaxRes];
  logic [1:0]      nbytes;
  logic            emit_status;
  logic            err_now;
  logic            tail_go;
  logic            tail_n3;
  logic [1:0]      total;
  logic [LenW+1:0] cnt_sum;
  logic [LenW-1:0] cnt_new;

  assign fire     = stg_vld_q && room_i;
  assign in_rdy_o = !stg_vld_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      stg_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      stg_kind_q <= in_kind_i;
      stg_char_q <= in_char_i;
    end
  end

  assign sx0 = sextet(held_q[0], alph_sel_i);
  assign sx1 = sextet(held_q[1], alph_sel_i);
  assign sx2 = sextet(held_q[2], alph_sel_i);
  assign sx3 = sextet(stg_char_q, alph_sel_i);

  // tail bytes use the same bit layout as the first two group bytes
  assign bsel[0] = {sx0[5:0], sx1[5:4]};
  assign bsel[1] = {sx1[3:0], sx2[5:2]};
  assign bsel[2] = {sx2[1:0], sx3[5:0]};

  always_comb begin
    fill_d      = fill_q;
    pend_d      = pend_q;
    tail3_d     = tail3_q;
    err_d       = err_q;
    held_we     = 1'b0;
    nbytes      = 2'd0;
    emit_status = 1'b0;
    err_now     = err_q;
    tail_go     = 1'b0;
    tail_n3     = 1'b0;
    if (fire) begin
      if (in_kind_e'(stg_kind_q) == KIND_CHAR) begin
        if (err_q) begin
          // string already invalid, drop characters
        end else if (pend_q) begin
          err_d = 1'b1;
        end else if (fill_q != 2'd3) begin
          held_we = 1'b1;
          fill_d  = fill_q + 2'd1;
        end else begin
          fill_d = 2'd0;
          if (sx0[6] || sx1[6] || sx2[6] || sx3[6]) begin
            if (pad_on_i && stg_char_q == CharPad) begin
              pend_d  = 1'b1;
              tail3_d = (held_q[2] != CharPad);
            end else begin
              err_d = 1'b1;
            end
          end else begin
            nbytes = 2'd3;
          end
        end
      end else begin
        if (!err_q) begin
          if (pend_q) begin
            tail_go = 1'b1;
            tail_n3 = tail3_q;
          end else if (fill_q != 2'd0) begin
            if (pad_on_i || fill_q == 2'd1) begin
              err_now = 1'b1;
            end else begin
              tail_go = 1'b1;
              tail_n3 = (fill_q == 2'd3);
            end
          end
        end
        if (tail_go) begin
          if (sx0[6] || sx1[6] || (tail_n3 && sx2[6])) begin
            err_now = 1'b1;
          end else if (!tail_n3) begin
            if (sx1[3:0] != 4'd0) err_now = 1'b1;
            else nbytes = 2'd1;
          end else begin
            if (sx2[1:0] != 2'd0) err_now = 1'b1;
            else nbytes = 2'd2;
          end
        end
        emit_status = 1'b1;
        fill_d      = 2'd0;
        pend_d      = 1'b0;
        tail3_d     = 1'b0;
        err_d       = 1'b0;
      end
    end
  end

  assign cnt_sum = {2'b00, cnt_q} + {{LenW{1'b0}}, nbytes};
  assign cnt_new = (cnt_sum > {2'b00, LenCap}) ? LenCap : cnt_sum[LenW-1:0];
  assign cnt_d   = (fire && in_kind_e'(stg_kind_q) == KIND_END) ? '0 : cnt_new;
  assign total   = nbytes + {1'b0, emit_status};

  always_comb begin
    push_o.cnt = total;
    for (int i = 0; i < MaxRes; i++) begin
      push_o.res[i] = '0;
      if (2'(i) < nbytes) begin
        push_o.res[i].result_kind = RES_DATA;
        push_o.res[i].data_byte   = bsel[i];
      end else if (emit_status && 2'(i) == nbytes) begin
        push_o.res[i].result_kind    = RES_STATUS;
        push_o.res[i].status         = err_now;
        push_o.res[i].decoded_length = cnt_new;
      end
      push_o.res[i].last_in_run = (2'(i + 1) == total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 2'd0;
      pend_q  <= 1'b0;
      tail3_q <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      tail3_q <= tail3_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[fill_q] <= stg_char_q;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stg_kind_q == KIND_END |=> fill_q == 2'd0 && !pend_q && !err_q && cnt_q == '0)
    else $error("per-string state not cleared after end transaction");

  a_pend_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> fill_q == 2'd0)
    else $error("padded group pending while group partly filled");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt != 2'd0 |-> push_o.res[push_o.cnt - 2'd1].last_in_run)
    else $error("last result of a transaction not marked");

endmodule

// ----- src/b64d_res_fifo.sv -----
module b64d_res_fifo import b64d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  out_vld_o,
  input  logic  out_rdy_i,
  output res_t  out_res_o
);

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic [ResCntW-1:0] cnt_after;
  logic               pop;

  assign pop       = (cnt_q != '0) && out_rdy_i;
  assign cnt_after = cnt_q - ResCntW'(pop);
  // room for a full transaction worth of results
  assign room_o    = cnt_after <= ResCntW'(ResDepth - MaxRes);
  assign cnt_d     = cnt_after + ResCntW'(push_i.cnt);
  assign out_vld_o = (cnt_q != '0);
  assign out_res_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + ResPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxRes; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + ResPtrW'(i)] <= push_i.res[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |-> cnt_after + ResCntW'(push_i.cnt) <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ResCntW'(ResDepth))
    else $error("result queue count out of range");

endmodule

// ----- src/base64_decoder_multi_variant.sv -----
// Streaming Base64 decoder, one character transaction per cycle on in_i while it
// is ready. The alphabet (standard, URL-safe, IMAP) and '=' padding are set
// through cfg_i, which the user must write only while the block is idle; the
// block does not enforce this. A character is held in an input register, is
// decoded there and its results (up to three: a full group gives three bytes at
// once, an end transaction gives the tail bytes plus a status) go into an
// eight-entry result queue that drains on out_o. The input stalls only when the
// queue cannot take three more results, so with out_o always ready the block
// keeps one character per cycle and drains one result per cycle.
module base64_decoder_multi_variant import b64d_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  b64d_char_if.sink   in_i,
  b64d_res_if.source  out_o,
  b64d_cfg_if.sink    cfg_i
);

  logic [1:0] variant_q, variant_d;
  logic       pad_on_q, pad_on_d;
  logic       room;
  push_t      push;
  res_t       out_res;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    variant_d = variant_q;
    pad_on_d  = pad_on_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_VARIANT: variant_d = cfg_i.data[1:0];
        REG_PADDING: pad_on_d  = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_STD;
      pad_on_q  <= 1'b1;
    end else begin
      variant_q <= variant_d;
      pad_on_q  <= pad_on_d;
    end
  end

  b64d_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_char_i  (in_i.char_code),
    .in_rdy_o   (in_i.ready),
    .room_i     (room),
    .alph_sel_i (variant_q),
    .pad_on_i   (pad_on_q),
    .push_o     (push)
  );

  b64d_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .room_o    (room),
    .out_vld_o (out_o.valid),
    .out_rdy_i (out_o.ready),
    .out_res_o (out_res)
  );

  assign out_o.result_kind    = out_res.result_kind;
  assign out_o.data_byte      = out_res.data_byte;
  assign out_o.status         = out_res.status;
  assign out_o.decoded_length = out_res.decoded_length;
  assign out_o.last_in_run    = out_res.last_in_run;

endmodule
